>>> sv/pam_pkg.sv
// ----------------------------------------------------------------------------
// pam_pkg
// Shared types, widths and constants for the PDU power alarm manager.
// ----------------------------------------------------------------------------
package pam_pkg;

    localparam int NUM_INPUTS_DEF = 6;
    localparam int TIME_BITS_DEF  = 32;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 3;
    localparam int VOLT_W     = 16;
    localparam int CUR_W      = 16;
    localparam int CNT_W      = 3;
    localparam int NOW_W      = 32;
    localparam int ID_W       = 5;
    localparam int UNACK_W    = 5;
    localparam int RATED_W    = 8;
    localparam int SYS_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int N_IDS       = 20;
    localparam int SLOTS       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ID_W-1:0] ID_COMM = 5'd0;
    localparam logic [ID_W-1:0] ID_NET  = 5'd19;

    // warning-class ids: every near-current alarm and network down
    localparam logic [N_IDS-1:0] WARN_MASK = 20'hC9248;

    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [6:0] PCT_NEAR = 7'd90;

    localparam logic [VOLT_W-1:0] VMIN_RESET = 16'd200;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_ROUND  = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RATED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VMIN   = 2'd3;

    typedef enum logic [1:0] {
        K_SAMPLE,
        K_ROUND,
        K_ACK
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [VOLT_W-1:0]  voltage;
        logic [CUR_W-1:0]   current;
        logic [CNT_W-1:0]   count;
        logic               power_valid;
        logic               comm_fault;
        logic               net_valid;
        logic               net_connected;
        logic [NOW_W-1:0]   now;
        logic [ID_W-1:0]    alarm_id;
    } t_cmd;

    function automatic logic severity_of(input logic [ID_W-1:0] id);
        logic sev;
        sev = 1'b1;
        if (id < ID_W'(N_IDS)) begin
            sev = ~WARN_MASK[id];
        end
        return sev;
    endfunction

endpackage

>>> sv/pam_in_if.sv
// ----------------------------------------------------------------------------
// pam_in_if
// Input word channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface pam_in_if;
    logic                           valid;
    logic                           ready;
    logic [pam_pkg::OP_W-1:0]       op;
    logic [pam_pkg::IDX_W-1:0]      input_index;
    logic [pam_pkg::VOLT_W-1:0]     voltage_dv;
    logic [pam_pkg::CUR_W-1:0]      current_ca;
    logic [pam_pkg::CNT_W-1:0]      inputs_reported;
    logic                           power_valid;
    logic                           comm_fault;
    logic                           network_valid;
    logic                           network_connected;
    logic [pam_pkg::NOW_W-1:0]      now_seconds;
    logic [pam_pkg::ID_W-1:0]       alarm_id;

    modport source (
        output valid, op, input_index, voltage_dv, current_ca, inputs_reported,
               power_valid, comm_fault, network_valid, network_connected,
               now_seconds, alarm_id,
        input  ready
    );

    modport sink (
        input  valid, op, input_index, voltage_dv, current_ca, inputs_reported,
               power_valid, comm_fault, network_valid, network_connected,
               now_seconds, alarm_id,
        output ready
    );
endinterface

>>> sv/pam_out_if.sv
// ----------------------------------------------------------------------------
// pam_out_if
// Result word channel: valid/ready handshake with the alarm/summary fields.
// ----------------------------------------------------------------------------
interface pam_out_if;
    logic                           valid;
    logic                           ready;
    logic [pam_pkg::ID_W-1:0]       out_alarm_id;
    logic                           severity;
    logic                           acked;
    logic [pam_pkg::NOW_W-1:0]      raised_at;
    logic                           changed;
    logic [pam_pkg::UNACK_W-1:0]    unacked_count;
    logic                           last;

    modport source (
        output valid, out_alarm_id, severity, acked, raised_at, changed,
               unacked_count, last,
        input  ready
    );

    modport sink (
        input  valid, out_alarm_id, severity, acked, raised_at, changed,
               unacked_count, last,
        output ready
    );
endinterface

>>> sv/pam_front.sv
// ----------------------------------------------------------------------------
// pam_front
// Accepts input words, drops ones with no effect and queues the rest.
// ----------------------------------------------------------------------------
module pam_front #(
    parameter int NUM_INPUTS = pam_pkg::NUM_INPUTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pam_in_if.sink          i_in,
    output pam_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_pop
);

    localparam int PW = (pam_pkg::QUEUE_DEPTH > 1) ? $clog2(pam_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(pam_pkg::QUEUE_DEPTH + 1);

    pam_pkg::t_cmd  r_q [pam_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    pam_pkg::t_cmd  w_cmd;
    logic           w_keep;
    logic           w_push;

    always_comb begin
        w_cmd.kind          = pam_pkg::K_SAMPLE;
        w_cmd.idx           = i_in.input_index;
        w_cmd.voltage       = i_in.voltage_dv;
        w_cmd.current       = i_in.current_ca;
        w_cmd.count         = i_in.inputs_reported;
        w_cmd.power_valid   = i_in.power_valid;
        w_cmd.comm_fault    = i_in.comm_fault;
        w_cmd.net_valid     = i_in.network_valid;
        w_cmd.net_connected = i_in.network_connected;
        w_cmd.now           = i_in.now_seconds;
        w_cmd.alarm_id      = i_in.alarm_id;
        w_keep              = 1'b0;
        unique case (i_in.op)
            pam_pkg::OP_SAMPLE: begin
                w_cmd.kind = pam_pkg::K_SAMPLE;
                w_keep     = ({1'b0, i_in.input_index} < (pam_pkg::IDX_W + 1)'(NUM_INPUTS));
            end
            pam_pkg::OP_ROUND: begin
                w_cmd.kind = pam_pkg::K_ROUND;
                w_keep     = 1'b1;
            end
            pam_pkg::OP_ACK: begin
                w_cmd.kind = pam_pkg::K_ACK;
                w_keep     = (i_in.alarm_id < pam_pkg::ID_W'(pam_pkg::N_IDS));
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = (r_cnt != CW'(pam_pkg::QUEUE_DEPTH));
    assign w_push      = i_in.valid && i_in.ready && w_keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(pam_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");

    a_push_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_cmd_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");

endmodule

>>> sv/pam_back.sv
// ----------------------------------------------------------------------------
// pam_back
// Executes queued words: stores samples, sets acks, evaluates rounds and
// lists the active alarms followed by a summary word.
// ----------------------------------------------------------------------------
module pam_back #(
    parameter int NUM_INPUTS = pam_pkg::NUM_INPUTS_DEF,
    parameter int TIME_BITS  = pam_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pam_pkg::t_cmd                       i_cmd,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_pop,
    input  logic                                i_cfg_we,
    input  logic [pam_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pam_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    pam_out_if.source                           o_out
);

    localparam int SW      = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int N_EVAL  = (NUM_INPUTS < pam_pkg::SLOTS) ? NUM_INPUTS : pam_pkg::SLOTS;
    localparam int STAMP_W = (TIME_BITS < pam_pkg::NOW_W) ? TIME_BITS : pam_pkg::NOW_W;
    localparam int N_IDS   = pam_pkg::N_IDS;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state                             r_state;
    logic [pam_pkg::RATED_W-1:0]        r_rated;
    logic [pam_pkg::SYS_W-1:0]          r_system;
    logic                               r_branch;
    logic [pam_pkg::VOLT_W-1:0]         r_vmin;

    logic [pam_pkg::VOLT_W-1:0]         r_sv [NUM_INPUTS];
    logic [pam_pkg::CUR_W-1:0]          r_sc [NUM_INPUTS];
    logic [STAMP_W-1:0]                 r_raise [N_IDS];

    logic [N_IDS-1:0]                   r_active;
    logic [N_IDS-1:0]                   r_ack;
    logic [N_IDS-1:0]                   r_scan;
    logic                               r_changed;
    logic [pam_pkg::UNACK_W-1:0]        r_unacked;

    logic                               r_out_valid;
    logic [pam_pkg::ID_W-1:0]           r_o_id;
    logic                               r_o_sev;
    logic                               r_o_ack;
    logic [pam_pkg::NOW_W-1:0]          r_o_raise;
    logic                               r_o_changed;
    logic [pam_pkg::UNACK_W-1:0]        r_o_unacked;
    logic                               r_o_last;

    logic [1:0]                         w_phases;
    logic [2:0]                         w_limit;
    logic [14:0]                        w_full;
    logic [14:0]                        w_near;
    logic [2:0]                         w_slot [pam_pkg::SLOTS];
    logic [N_IDS-1:0]                   w_next;
    logic [N_IDS-1:0]                   w_ack_bit;
    logic [pam_pkg::ID_W-1:0]           w_pick;
    logic                               w_out_free;
    logic                               w_round;
    logic                               w_sample;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rated  <= '0;
            r_system <= '0;
            r_branch <= 1'b0;
            r_vmin   <= pam_pkg::VMIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pam_pkg::CFG_RATED:  r_rated  <= i_cfg_data[pam_pkg::RATED_W-1:0];
                pam_pkg::CFG_SYSTEM: r_system <= i_cfg_data[pam_pkg::SYS_W-1:0];
                pam_pkg::CFG_BRANCH: r_branch <= i_cfg_data[0];
                pam_pkg::CFG_VMIN:   r_vmin   <= i_cfg_data[pam_pkg::VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign w_round   = o_cmd_pop && (i_cmd.kind == pam_pkg::K_ROUND);
    assign w_sample  = o_cmd_pop && (i_cmd.kind == pam_pkg::K_SAMPLE);

    // round evaluation
    always_comb begin
        unique case (r_system)
            2'd0:    w_phases = 2'd1;
            2'd1:    w_phases = 2'd2;
            default: w_phases = 2'd3;
        endcase
        w_limit = r_branch ? {w_phases, 1'b0} : {1'b0, w_phases};
        w_full  = 15'(r_rated) * 15'(pam_pkg::PCT_FULL);
        w_near  = 15'(r_rated) * 15'(pam_pkg::PCT_NEAR);
    end

    for (genvar g = 0; g < pam_pkg::SLOTS; g++) begin : g_slot
        if (g < N_EVAL) begin : g_eval
            logic w_en;
            logic w_over;
            assign w_en   = i_cmd.power_valid && (3'(g) < w_limit) && (3'(g) < i_cmd.count);
            assign w_over = ({1'b0, r_sc[g]} > 17'(w_full));
            assign w_slot[g][0] = w_en && (r_sv[g] < r_vmin);
            assign w_slot[g][1] = w_en && (r_rated != '0) && w_over;
            assign w_slot[g][2] = w_en && (r_rated != '0) && !w_over
                                  && ({1'b0, r_sc[g]} > 17'(w_near));
        end else begin : g_none
            assign w_slot[g] = '0;
        end
    end

    always_comb begin
        w_next = '0;
        w_next[pam_pkg::ID_COMM] = i_cmd.comm_fault;
        for (int k = 0; k < pam_pkg::SLOTS; k++) begin
            w_next[1 + 3 * k +: 3] = w_slot[k];
        end
        w_next[pam_pkg::ID_NET] = i_cmd.net_valid && !i_cmd.net_connected;
    end

    assign w_ack_bit = N_IDS'(1) << i_cmd.alarm_id;

    always_comb begin
        w_pick = '0;
        for (int k = N_IDS - 1; k >= 0; k--) begin
            if (r_scan[k]) begin
                w_pick = pam_pkg::ID_W'(k);
            end
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    // sample store
    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_sv[i_cmd.idx[SW-1:0]] <= i_cmd.voltage;
            r_sc[i_cmd.idx[SW-1:0]] <= i_cmd.current;
        end
    end

    // raise time store
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_IDS; k++) begin
            if (w_round && w_next[k] && !r_active[k]) begin
                r_raise[k] <= i_cmd.now[STAMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_ack       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_LIST)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        case (i_cmd.kind)
                            pam_pkg::K_ROUND: begin
                                r_ack     <= r_ack & w_next & r_active;
                                r_active  <= w_next;
                                r_changed <= (w_next != r_active);
                                r_scan    <= w_next;
                                r_unacked <= '0;
                                r_state   <= S_LIST;
                            end
                            pam_pkg::K_ACK: begin
                                r_ack <= r_ack | (w_ack_bit & r_active);
                            end
                            default: ;
                        endcase
                    end
                end
                S_LIST: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_scan == '0) begin
                            r_o_id      <= '0;
                            r_o_sev     <= 1'b0;
                            r_o_ack     <= 1'b0;
                            r_o_raise   <= '0;
                            r_o_changed <= r_changed;
                            r_o_unacked <= r_unacked;
                            r_o_last    <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_o_id       <= w_pick;
                            r_o_sev      <= pam_pkg::severity_of(w_pick);
                            r_o_ack      <= r_ack[w_pick];
                            r_o_raise    <= pam_pkg::NOW_W'(r_raise[w_pick]);
                            r_o_changed  <= 1'b0;
                            r_o_unacked  <= '0;
                            r_o_last     <= 1'b0;
                            r_scan[w_pick] <= 1'b0;
                            if (!r_ack[w_pick]) begin
                                r_unacked <= r_unacked + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_alarm_id  = r_o_id;
    assign o_out.severity      = r_o_sev;
    assign o_out.acked         = r_o_ack;
    assign o_out.raised_at     = r_o_raise;
    assign o_out.changed       = r_o_changed;
    assign o_out.unacked_count = r_o_unacked;
    assign o_out.last          = r_o_last;

    a_ack_in_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ack & ~r_active) == '0)
        else $error("ack set on inactive alarm");

    a_scan_in_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> ((r_scan & ~r_active) == '0))
        else $error("listing an inactive alarm");

    a_item_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_last) |-> r_active[r_o_id])
        else $error("alarm word for inactive id");

    a_unacked_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_last) |-> (r_o_unacked <= pam_pkg::UNACK_W'(N_IDS)))
        else $error("unacked count out of range");

endmodule

>>> sv/pdu_power_alarm_manager.sv
// ----------------------------------------------------------------------------
// pdu_power_alarm_manager
// Power alarm tracking for a PDU: samples, round evaluation, acknowledges.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries words of three kinds: sample (store one input's voltage and
//   current), end of round (evaluate alarms), acknowledge (mark an alarm).
//   Words with no effect (reserved op, slot or alarm id out of range) are
//   accepted and dropped. Accepted words go into a two-entry queue; i_in is
//   ready whenever the queue has room, so a word can be taken every cycle.
//   The executing side takes one queued word per cycle for samples and
//   acknowledges while not listing. An end of round is evaluated, then each
//   active alarm is listed on o_out in ascending id order, then the summary
//   word (last = 1); the listing sequencer emits one word per cycle while
//   o_out is not stalled. With the queue empty, a round word goes through
//   the queue entry and the state register into the output register.
//   o_out is driven from an output register; while the receiver stalls the
//   listing waits and the input queue keeps filling until full. The user
//   must write configuration through i_cfg_we/i_cfg_index/i_cfg_data only
//   while the block is idle; the block does not enforce it. Synchronous reset
//   clears alarm/ack state, queue and config (dead-voltage threshold 20.0 V).
// ----------------------------------------------------------------------------
module pdu_power_alarm_manager #(
    parameter int NUM_INPUTS = pam_pkg::NUM_INPUTS_DEF,
    parameter int TIME_BITS  = pam_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pam_in_if.sink                          i_in,
    pam_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [pam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pam_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pam_pkg::t_cmd  w_cmd;
    logic           w_cmd_valid;
    logic           w_cmd_pop;

    pam_front #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    pam_back #(
        .NUM_INPUTS (NUM_INPUTS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PDU power alarm manager. Sample, round and
// acknowledge words are queued by a stimulus process and fed to the input
// channel. A driver and a monitor run as clocked processes, each with random
// gaps. A scoreboard model predicts every alarm and summary word. The run
// goes through several register settings, one of them with a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pam_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

    localparam int N_SETTINGS    = 7;
    localparam int HOLD_PHASE    = 5;
    localparam int PHASE_WORDS   = 23;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;

    localparam int SET_RATED  [N_SETTINGS] = '{0, 255, 1, 128, 255, 50, 7};
    localparam int SET_SYSTEM [N_SETTINGS] = '{0, 3, 1, 2, 0, 3, 1};
    localparam int SET_BRANCH [N_SETTINGS] = '{0, 1, 0, 1, 1, 0, 1};
    localparam int SET_VMIN   [N_SETTINGS] = '{200, 65535, 0, 2000, 1, 200, 65534};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [VOLT_W-1:0] volt;
        logic [CUR_W-1:0]  cur;
        logic [CNT_W-1:0]  count;
        logic              pv;
        logic              ce;
        logic              nv;
        logic              nc;
        logic [NOW_W-1:0]  now;
        logic [ID_W-1:0]   aid;
    } t_pdu_word;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               severity;
        logic               acked;
        logic [NOW_W-1:0]   raised_at;
        logic               changed;
        logic [UNACK_W-1:0] unacked;
        logic               last;
    } t_alarm_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pam_in_if  in_ch ();
    pam_out_if out_ch ();

    pdu_power_alarm_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // scoreboard model state
    logic [RATED_W-1:0] cfg_rated;
    logic [SYS_W-1:0]   cfg_system;
    logic               cfg_branch;
    logic [VOLT_W-1:0]  cfg_vmin;
    logic [VOLT_W-1:0]  m_volt [SLOTS];
    logic [CUR_W-1:0]   m_cur [SLOTS];
    logic [N_IDS-1:0]   m_active;
    logic [N_IDS-1:0]   m_acked;
    logic [NOW_W-1:0]   m_raised [N_IDS];

    t_pdu_word   pending_words [$];
    t_alarm_word alarm_words_due [$];
    t_pdu_word   in_flight;
    t_alarm_word due_word;

    int fails = 0;
    int words_taken = 0;
    int rounds_taken = 0;
    int acks_taken = 0;
    int results_seen = 0;
    int stim_count = 0;
    int hold_reqs = 0;
    int holds_done = 0;
    int send_gap = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit steady_flow = 1'b0;
    logic [NOW_W-1:0] wall_clock = '0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int slots_in_use();
        int phases;
        phases = (cfg_system == 2'd0) ? 1 : (cfg_system == 2'd1) ? 2 : 3;
        return phases * (cfg_branch ? 2 : 1);
    endfunction

    function automatic logic alarm_is_error(input int id);
        if (id == int'(ID_COMM)) return 1'b1;
        if (id == int'(ID_NET)) return 1'b0;
        return ((id - 1) % 3 == 2) ? 1'b0 : 1'b1;
    endfunction

    function automatic void predict_word(input t_pdu_word w);
        logic [N_IDS-1:0] nxt;
        t_alarm_word r;
        int slot, base, unacked;
        nxt = '0;
        unacked = 0;
        case (w.op)
            OP_SAMPLE: begin
                if (w.idx < SLOTS) begin
                    m_volt[w.idx] = w.volt;
                    m_cur[w.idx] = w.cur;
                end
            end
            OP_ACK: begin
                acks_taken++;
                if (w.aid < N_IDS) m_acked |= m_active & (N_IDS'(1) << w.aid);
            end
            OP_ROUND: begin
                rounds_taken++;
                if (w.ce) nxt[ID_COMM] = 1'b1;
                if (w.pv) begin
                    for (slot = 0; slot < slots_in_use(); slot++) begin
                        base = 1 + 3 * slot;
                        if (slot >= w.count || slot >= SLOTS || base + 2 >= ID_NET) continue;
                        if (m_volt[slot] < cfg_vmin) nxt[base] = 1'b1;
                        if (cfg_rated != 0) begin
                            if (m_cur[slot] > cfg_rated * 100) nxt[base + 1] = 1'b1;
                            else if (m_cur[slot] > cfg_rated * 90) nxt[base + 2] = 1'b1;
                        end
                    end
                end
                if (w.nv && !w.nc) nxt[ID_NET] = 1'b1;
                for (int i = 0; i < N_IDS; i++) begin
                    if (nxt[i] && !m_active[i]) m_raised[i] = w.now;
                end
                r = '0;
                r.changed = (nxt != m_active);
                m_acked &= nxt & m_active;
                m_active = nxt;
                for (int i = 0; i < N_IDS; i++) begin
                    if (m_active[i]) begin
                        due_word = '0;
                        due_word.id = ID_W'(i);
                        due_word.severity = alarm_is_error(i);
                        due_word.acked = m_acked[i];
                        due_word.raised_at = m_raised[i];
                        alarm_words_due.push_back(due_word);
                        if (!m_acked[i]) unacked++;
                    end
                end
                r.unacked = UNACK_W'(unacked);
                r.last = 1'b1;
                alarm_words_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic t_pdu_word scrambled_word(input logic [OP_W-1:0] op);
        t_pdu_word w;
        w.op = op;
        w.idx = IDX_W'($urandom);
        w.volt = VOLT_W'($urandom);
        w.cur = CUR_W'($urandom);
        w.count = CNT_W'($urandom);
        w.pv = 1'($urandom);
        w.ce = 1'($urandom);
        w.nv = 1'($urandom);
        w.nc = 1'($urandom);
        w.now = $urandom;
        w.aid = ID_W'($urandom);
        return w;
    endfunction

    function automatic t_pdu_word sample_of(input int slot, input logic [15:0] v,
                                            input logic [15:0] c);
        t_pdu_word w;
        w = scrambled_word(OP_SAMPLE);
        w.idx = IDX_W'(slot);
        w.volt = v;
        w.cur = c;
        return w;
    endfunction

    function automatic t_pdu_word round_of(input int count, input bit pv, input bit ce,
                                           input bit nv, input bit nc,
                                           input logic [NOW_W-1:0] now);
        t_pdu_word w;
        w = scrambled_word(OP_ROUND);
        w.count = CNT_W'(count);
        w.pv = pv;
        w.ce = ce;
        w.nv = nv;
        w.nc = nc;
        w.now = now;
        return w;
    endfunction

    function automatic t_pdu_word ack_of(input logic [ID_W-1:0] id);
        t_pdu_word w;
        w = scrambled_word(OP_ACK);
        w.aid = id;
        return w;
    endfunction

    function automatic void queue_word(input t_pdu_word w);
        pending_words.push_back(w);
        if (w.op != OP_RSVD && !(w.op == OP_SAMPLE && w.idx >= SLOTS)) stim_count++;
    endfunction

    function automatic logic [15:0] near_level(input int base);
        int v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 65535;
            2: v = $urandom_range(0, 65535);
            default: v = base + int'($urandom_range(0, 4)) - 2;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [ID_W-1:0] pick_ack_id();
        int id;
        id = $urandom_range(0, N_IDS - 1);
        if (m_active != '0 && $urandom_range(0, 2) != 0) begin
            while (!m_active[id]) id = $urandom_range(0, N_IDS - 1);
        end
        return ID_W'(id);
    endfunction

    function automatic void queue_round_cycle();
        int slots, count;
        slots = slots_in_use();
        for (int i = 0; i < slots; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                queue_word(sample_of(i, near_level(cfg_vmin),
                    near_level(cfg_rated * ($urandom_range(0, 1) ? 100 : 90))));
            end
        end
        for (int i = $urandom_range(0, 2); i > 0; i--) queue_word(ack_of(pick_ack_id()));
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : slots;
        wall_clock += $urandom_range(1, 100);
        queue_word(round_of(count, $urandom_range(0, 5) != 0, $urandom_range(0, 3) == 0,
            1'($urandom), 1'($urandom),
            ($urandom_range(0, 9) == 0) ? NOW_W'($urandom) : wall_clock));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expd,
                                        input logic [31:0] act);
        if (act !== expd) begin
            $error("%s: expected %0h, got %0h", name, expd, act);
            fails++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
    endtask

    task automatic apply_setting(input int rated, input int sys, input int br,
                                 input int vmin);
        write_reg(CFG_RATED, rated);
        write_reg(CFG_SYSTEM, sys);
        write_reg(CFG_BRANCH, br);
        write_reg(CFG_VMIN, vmin);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_rated = RATED_W'(rated);
        cfg_system = SYS_W'(sys);
        cfg_branch = 1'(br);
        cfg_vmin = VOLT_W'(vmin);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || in_ch.valid || alarm_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(in_flight);
                words_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    in_flight = pending_words.pop_front();
                    in_ch.op <= in_flight.op;
                    in_ch.input_index <= in_flight.idx;
                    in_ch.voltage_dv <= in_flight.volt;
                    in_ch.current_ca <= in_flight.cur;
                    in_ch.inputs_reported <= in_flight.count;
                    in_ch.power_valid <= in_flight.pv;
                    in_ch.comm_fault <= in_flight.ce;
                    in_ch.network_valid <= in_flight.nv;
                    in_ch.network_connected <= in_flight.nc;
                    in_ch.now_seconds <= in_flight.now;
                    in_ch.alarm_id <= in_flight.aid;
                    in_ch.valid <= 1'b1;
                    send_gap = steady_flow ? 0 : pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (alarm_words_due.size() == 0) begin
                    $error("result word with nothing expected: id %0d last %0b",
                        out_ch.out_alarm_id, out_ch.last);
                    fails++;
                end else begin
                    due_word = alarm_words_due.pop_front();
                    check_field("out_alarm_id", 32'(due_word.id), 32'(out_ch.out_alarm_id));
                    check_field("severity", 32'(due_word.severity), 32'(out_ch.severity));
                    check_field("acked", 32'(due_word.acked), 32'(out_ch.acked));
                    check_field("raised_at", due_word.raised_at, out_ch.raised_at);
                    check_field("changed", 32'(due_word.changed), 32'(out_ch.changed));
                    check_field("unacked_count", 32'(due_word.unacked),
                        32'(out_ch.unacked_count));
                    check_field("last", 32'(due_word.last), 32'(out_ch.last));
                end
            end
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && !steady_flow) begin
                hold_left = pick_gap();
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.input_index = '0;
        in_ch.voltage_dv = '0;
        in_ch.current_ca = '0;
        in_ch.inputs_reported = '0;
        in_ch.power_valid = 1'b0;
        in_ch.comm_fault = 1'b0;
        in_ch.network_valid = 1'b0;
        in_ch.network_connected = 1'b0;
        in_ch.now_seconds = '0;
        in_ch.alarm_id = '0;
        out_ch.ready = 1'b0;
        cfg_rated = '0;
        cfg_system = '0;
        cfg_branch = 1'b0;
        cfg_vmin = VMIN_RESET;
        m_active = '0;
        m_acked = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: boundaries of every compare, acks good and bad, ignored words
        apply_setting(10, 2, 1, 200);
        queue_word(sample_of(0, 16'd0, 16'd0));
        queue_word(sample_of(1, 16'hFFFF, 16'hFFFF));
        queue_word(sample_of(2, 16'd199, 16'd901));
        queue_word(sample_of(3, 16'd200, 16'd900));
        queue_word(sample_of(4, 16'd2300, 16'd1000));
        queue_word(sample_of(5, 16'd2300, 16'd1001));
        queue_word(round_of(6, 1, 1, 1, 0, 32'hFFFF_FFFF));
        queue_word(ack_of(ID_COMM));
        queue_word(ack_of(ID_NET));
        queue_word(ack_of(5'd31));
        queue_word(ack_of(5'd3));
        queue_word(ack_of(5'd20));
        queue_word(scrambled_word(OP_RSVD));
        queue_word(sample_of(6, 16'hFFFF, 16'hFFFF));
        queue_word(sample_of(7, 16'h0000, 16'hFFFF));
        queue_word(round_of(6, 1, 1, 1, 0, 32'd0));
        queue_word(sample_of(0, 16'd230, 16'd0));
        queue_word(round_of(1, 1, 0, 0, 0, 32'd5));
        queue_word(round_of(6, 0, 0, 1, 1, 32'd6));
        queue_word(round_of(0, 1, 0, 0, 0, 32'd7));
        queue_word(round_of(7, 1, 1, 1, 1, 32'h8000_0000));
        queue_word(ack_of(5'd5));
        queue_word(round_of(6, 1, 0, 1, 0, 32'd9));
        wait_idle();

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            apply_setting(SET_RATED[ph], SET_SYSTEM[ph], SET_BRANCH[ph], SET_VMIN[ph]);
            if (ph == HOLD_PHASE) begin
                steady_flow = 1'b1;
                hold_reqs++;
            end else begin
                steady_flow = ($urandom_range(0, 3) == 0);
            end
            for (int target = stim_count + PHASE_WORDS; stim_count < target; ) begin
                if ($urandom_range(0, 9) < 7) queue_round_cycle();
                else queue_word(scrambled_word(OP_W'($urandom)));
            end
            wait_idle();
            steady_flow = 1'b0;
        end

        $display("Covered %0d accepted words (%0d rounds, %0d acknowledges), %0d result words,",
            words_taken, rounds_taken, acks_taken, results_seen);
        $display("over %0d register settings including one long output hold-off.",
            N_SETTINGS + 1);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
